// ===== rtl/ehht_pkg.sv =====
// shared types and constants for the event handler hash table
package ehht_pkg;

    localparam int KEY_W  = 39;
    localparam int WORD_W = 32;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_HIT      = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;

    typedef struct packed {
        logic              lookup;
        logic [KEY_W-1:0]  key;
        logic [WORD_W-1:0] handler;
        logic [WORD_W-1:0] client;
        logic [WORD_W-1:0] bound;
    } req_t;

endpackage

// ===== rtl/ehht_front.sv =====
// front end: request capture and home slot hashing
module ehht_front #(
    parameter int TABLE_SIZE = 1021,
    parameter int IDX_W      = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  ehht_pkg::req_t        req,
    input  logic                  q_free,
    output logic                  q_push,
    output ehht_pkg::req_t        q_req,
    output logic [IDX_W-1:0]      q_home,
    output logic                  idle
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL   = 3'd1;
    localparam logic [2:0] F_FOLD  = 3'd2;
    localparam logic [2:0] F_RECIP = 3'd3;
    localparam logic [2:0] F_SUB   = 3'd4;
    localparam logic [2:0] F_OUT   = 3'd5;

    localparam int          SUM_W = 26;
    localparam int          SHR   = SUM_W + $clog2(TABLE_SIZE);
    localparam logic [63:0] TS64  = 64'(TABLE_SIZE);
    localparam logic [11:0] C1    = 12'((64'd1 << 12) % TS64);
    localparam logic [11:0] C2    = 12'((64'd1 << 24) % TS64);
    localparam logic [11:0] C3    = 12'((64'd1 << 36) % TS64);
    localparam logic [26:0] RECIP = 27'(((64'd1 << SHR) + TS64 - 64'd1) / TS64);

    logic [2:0]           state_reg, state_next;
    ehht_pkg::req_t       req_reg;
    logic [38:0]          prod_reg;
    logic [25:0]          sum_reg;
    logic [25:0]          quot_reg;
    logic [12:0]          rem_reg;
    logic [52:0]          scaled;

    assign scaled = 53'(sum_reg) * 53'(RECIP);
    assign idle   = (state_reg == F_IDLE);
    assign q_push = (state_reg == F_OUT) && q_free;
    assign q_req  = req_reg;
    assign q_home = rem_reg[IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (take) state_next = F_MUL;
            F_MUL:   state_next = F_FOLD;
            F_FOLD:  state_next = F_RECIP;
            F_RECIP: state_next = F_SUB;
            F_SUB:   state_next = F_OUT;
            F_OUT:   if (q_free) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // fold 12 bit digits of the product, then reciprocal reduction
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && take)
        begin
            req_reg <= req;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= 39'(req_reg.key[38:32]) * 39'(req_reg.key[31:0]);
        end
        if (state_reg == F_FOLD)
        begin
            sum_reg <= 26'(prod_reg[11:0])
                     + 26'(prod_reg[23:12]) * 26'(C1)
                     + 26'(prod_reg[35:24]) * 26'(C2)
                     + 26'(prod_reg[38:36]) * 26'(C3);
        end
        if (state_reg == F_RECIP)
        begin
            quot_reg <= 26'(scaled >> SHR);
        end
        if (state_reg == F_SUB)
        begin
            rem_reg <= 13'(sum_reg - quot_reg * 26'(TABLE_SIZE));
        end
    end

endmodule

// ===== rtl/ehht_queue.sv =====
// two entry queue between hashing and probing
module ehht_queue #(
    parameter int IDX_W = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ehht_pkg::req_t        in_req,
    input  logic [IDX_W-1:0]      in_home,
    input  logic                  pop,
    output logic                  free,
    output logic                  avail,
    output ehht_pkg::req_t        out_req,
    output logic [IDX_W-1:0]      out_home
);

    ehht_pkg::req_t    req_q [2];
    logic [IDX_W-1:0]  home_q [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;

    assign free     = (cnt_reg != 2'd2);
    assign avail    = (cnt_reg != 2'd0);
    assign out_req  = req_q[rp_reg];
    assign out_home = home_q[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            req_q[wp_reg]  <= in_req;
            home_q[wp_reg] <= in_home;
        end
    end

endmodule

// ===== rtl/ehht_back.sv =====
// back end: linear probe over the slot memory and result generation
module ehht_back #(
    parameter int TABLE_SIZE = 1021,
    parameter int IDX_W      = 10,
    parameter int CNT_W      = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  avail,
    input  ehht_pkg::req_t        req,
    input  logic [IDX_W-1:0]      home,
    output logic                  pop,
    output logic                  done,
    output logic [2:0]            status,
    output logic                  call_handler,
    output logic [31:0]           found_handler,
    output logic [31:0]           found_client,
    output logic [31:0]           found_bound,
    output logic [9:0]            entries_used
);

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_RD   = 3'd2;
    localparam logic [2:0] B_CHK  = 3'd3;
    localparam logic [2:0] B_DATA = 3'd4;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] TSC  = CNT_W'(TABLE_SIZE);

    logic                  vmem [TABLE_SIZE];
    logic [38:0]           kmem [TABLE_SIZE];
    logic [95:0]           dmem [TABLE_SIZE];

    logic [2:0]            state_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      used_reg;
    ehht_pkg::req_t        cur_reg;
    logic                  v_rd;
    logic [38:0]           k_rd;
    logic [95:0]           d_rd;
    logic [IDX_W-1:0]      nxt;
    logic                  idle;
    logic                  wr_v, wr_d;
    logic [IDX_W-1:0]      wa;
    logic                  done_reg;
    logic [2:0]            status_reg;
    logic                  call_reg;
    logic [95:0]           fd_reg;

    assign nxt   = (pos_reg == LAST) ? '0 : pos_reg + 1'b1;
    assign idle  = (state_reg == B_IDLE);
    assign pop   = idle && avail;
    assign done  = done_reg;
    assign status = status_reg;
    assign call_handler  = call_reg;
    assign found_handler = fd_reg[95:64];
    assign found_client  = fd_reg[63:32];
    assign found_bound   = fd_reg[31:0];
    assign entries_used  = 10'(used_reg);

    always_comb
    begin
        wr_v = 1'b0;
        wr_d = 1'b0;
        wa   = pos_reg;
        if (state_reg == B_CLR) wr_v = 1'b1;
        if (state_reg == B_CHK && !cur_reg.lookup)
        begin
            if (!v_rd)
            begin
                wr_v = 1'b1;
                wr_d = 1'b1;
            end
            else if (k_rd == cur_reg.key)
            begin
                wr_d = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_v) vmem[wa] <= (state_reg != B_CLR);
        if (wr_v && state_reg != B_CLR) kmem[wa] <= cur_reg.key;
        if (wr_d) dmem[wa] <= {cur_reg.handler, cur_reg.client, cur_reg.bound};
        v_rd <= vmem[pos_reg];
        k_rd <= kmem[pos_reg];
        d_rd <= dmem[pos_reg];
    end

    // clearing pass walks every slot after reset; then each probe reads a slot (B_RD) and checks it (B_CHK)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLR;
            pos_reg    <= '0;
            n_reg      <= '0;
            used_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ehht_pkg::ST_MISS;
            call_reg   <= 1'b0;
            fd_reg     <= '0;
            cur_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_CLR:
                begin
                    pos_reg <= nxt;
                    if (pos_reg == LAST) state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (avail)
                    begin
                        cur_reg   <= req;
                        pos_reg   <= home;
                        n_reg     <= '0;
                        state_reg <= B_RD;
                    end
                end
                B_RD: state_reg <= B_CHK;
                B_CHK:
                begin
                    fd_reg   <= '0;
                    call_reg <= 1'b0;
                    if (!v_rd)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                        if (cur_reg.lookup)
                        begin
                            status_reg <= ehht_pkg::ST_MISS;
                        end
                        else
                        begin
                            status_reg <= ehht_pkg::ST_INSERTED;
                            used_reg   <= used_reg + 1'b1;
                        end
                    end
                    else if (k_rd == cur_reg.key)
                    begin
                        if (cur_reg.lookup)
                        begin
                            state_reg <= B_DATA;
                        end
                        else
                        begin
                            status_reg <= ehht_pkg::ST_UPDATED;
                            done_reg   <= 1'b1;
                            state_reg  <= B_IDLE;
                        end
                    end
                    else if (n_reg == TSC - 1'b1)
                    begin
                        status_reg <= cur_reg.lookup ? ehht_pkg::ST_MISS
                                                     : ehht_pkg::ST_FULL;
                        done_reg   <= 1'b1;
                        state_reg  <= B_IDLE;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        pos_reg   <= nxt;
                        state_reg <= B_RD;
                    end
                end
                B_DATA:
                begin
                    status_reg <= ehht_pkg::ST_HIT;
                    fd_reg     <= d_rd;
                    call_reg   <= (d_rd[95:64] != '0);
                    done_reg   <= 1'b1;
                    state_reg  <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/event_handler_hash_table.sv =====
// top level of the event handler hash table
// A request is taken when start is high and busy low; its single result appears for one
// cycle with done high and cannot be stalled. The front end hashes the key
// (product, digit fold, reciprocal multiply, subtract, queue push) and takes no new request
// until the last one is pushed, which waits while the queue is full; the back end probes
// each slot of the slot memory with a read state and a check state. A lookup hit adds a
// data state before done, and the next request is hashed while the previous one probes.
// After reset a clearing pass over all TABLE_SIZE slots runs before the first request is
// probed.
module event_handler_hash_table #(
    parameter int TABLE_SIZE = 1021
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [6:0]  event_type,
    input  logic [31:0] window_id,
    input  logic [31:0] handler_id,
    input  logic [31:0] client_word,
    input  logic [31:0] bound_word,
    output logic        done,
    output logic [2:0]  status,
    output logic        call_handler,
    output logic [31:0] found_handler,
    output logic [31:0] found_client,
    output logic [31:0] found_bound,
    output logic [9:0]  entries_used
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);

    ehht_pkg::req_t    req, q_in, q_out;
    logic              f_idle, q_free, q_avail, q_push, q_pop;
    logic [IDX_W-1:0]  h_in, h_out;

    assign req  = '{lookup: req_type, key: {event_type, window_id},
                    handler: handler_id, client: client_word, bound: bound_word};
    assign busy = !f_idle;

    ehht_front #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W)) u_front (
        .clk(clk), .rst_n(rst_n), .take(start), .req(req), .q_free(q_free),
        .q_push(q_push), .q_req(q_in), .q_home(h_in), .idle(f_idle)
    );

    ehht_queue #(.IDX_W(IDX_W)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .in_req(q_in), .in_home(h_in),
        .pop(q_pop), .free(q_free), .avail(q_avail), .out_req(q_out), .out_home(h_out)
    );

    ehht_back #(.TABLE_SIZE(TABLE_SIZE), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(q_avail), .req(q_out), .home(h_out),
        .pop(q_pop), .done(done), .status(status),
        .call_handler(call_handler), .found_handler(found_handler),
        .found_client(found_client), .found_bound(found_bound),
        .entries_used(entries_used)
    );

endmodule

// ===== rtl/ehht_checker.sv =====
// port level checks for the event handler hash table
module ehht_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic        call_handler,
    input logic [31:0] found_handler
);

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ehht_pkg::ST_MISS) else $error("bad status");

    a_call: assert property (@(posedge clk) disable iff (!rst_n)
        done && call_handler |-> status == ehht_pkg::ST_HIT && found_handler != '0)
        else $error("call without hit");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ehht_pkg::ST_HIT |-> found_handler == '0 && !call_handler)
        else $error("data on non hit");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

endmodule

bind event_handler_hash_table ehht_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .call_handler(call_handler), .found_handler(found_handler)
);

// ===== bench/event_handler_hash_table_tb.sv =====
// testbench for the event handler hash table: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module event_handler_hash_table_tb;

    localparam int SLOTS      = 1021;
    localparam int CYCLE_CAP  = 20000000;
    localparam int RAND_ITEMS = 1400;

    typedef struct packed {
        logic [2:0]  status;
        logic        call_handler;
        logic [31:0] handler;
        logic [31:0] client;
        logic [31:0] bound;
        logic [9:0]  used;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [6:0]  event_type;
    logic [31:0] window_id;
    logic [31:0] handler_id;
    logic [31:0] client_word;
    logic [31:0] bound_word;
    logic        done;
    logic [2:0]  status;
    logic        call_handler;
    logic [31:0] found_handler;
    logic [31:0] found_client;
    logic [31:0] found_bound;
    logic [9:0]  entries_used;

    // predictor copy of the table
    logic        tbl_valid [SLOTS];
    logic [38:0] tbl_key [SLOTS];
    logic [31:0] tbl_handler [SLOTS];
    logic [31:0] tbl_client [SLOTS];
    logic [31:0] tbl_bound [SLOTS];
    int unsigned tbl_used;

    outcome_t    pending_outcomes[$];
    logic [38:0] stored_keys[$];
    int          errors;
    int unsigned cycles;
    bit          no_idle;

    event_handler_hash_table #(.TABLE_SIZE(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .event_type(event_type), .window_id(window_id),
        .handler_id(handler_id), .client_word(client_word), .bound_word(bound_word),
        .done(done), .status(status), .call_handler(call_handler),
        .found_handler(found_handler), .found_client(found_client),
        .found_bound(found_bound), .entries_used(entries_used)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("event_handler_hash_table_tb: FAIL");
            $finish;
        end
    end

    function automatic outcome_t table_lookup_update(logic rq, logic [6:0] typ,
                                                     logic [31:0] win, logic [31:0] hnd,
                                                     logic [31:0] cw, logic [31:0] bw);
        outcome_t    res;
        logic [38:0] key;
        logic [63:0] home;
        int unsigned k;
        int unsigned pos;
        bit          hit;
        res  = '0;
        key  = {typ, win};
        home = ({57'd0, typ} * {32'd0, win}) % SLOTS;
        k    = 32'(home);
        pos  = SLOTS;
        hit  = 0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!tbl_valid[k])
            begin
                pos = k;
                break;
            end
            if (tbl_key[k] == key)
            begin
                pos = k;
                hit = 1;
                break;
            end
            k = (k + 1 == SLOTS) ? 0 : k + 1;
        end
        if (rq == 1'b0)
        begin
            if (hit)
                res.status = ehht_pkg::ST_UPDATED;
            else if (pos < SLOTS)
            begin
                res.status     = ehht_pkg::ST_INSERTED;
                tbl_valid[pos] = 1'b1;
                tbl_key[pos]   = key;
                tbl_used++;
            end
            else
                res.status = ehht_pkg::ST_FULL;
            if (res.status != ehht_pkg::ST_FULL)
            begin
                tbl_handler[pos] = hnd;
                tbl_client[pos]  = cw;
                tbl_bound[pos]   = bw;
            end
        end
        else if (hit)
        begin
            res.status       = ehht_pkg::ST_HIT;
            res.handler      = tbl_handler[pos];
            res.client       = tbl_client[pos];
            res.bound        = tbl_bound[pos];
            res.call_handler = (tbl_handler[pos] != 0);
        end
        else
            res.status = ehht_pkg::ST_MISS;
        res.used = tbl_used[9:0];
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction, status %0d", $time, status);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, want.status, status);
                end
                if (call_handler !== want.call_handler)
                begin
                    errors++;
                    $display("%0t: call_handler exp %0d got %0d", $time,
                             want.call_handler, call_handler);
                end
                if (found_handler !== want.handler)
                begin
                    errors++;
                    $display("%0t: found_handler exp %h got %h", $time,
                             want.handler, found_handler);
                end
                if (found_client !== want.client)
                begin
                    errors++;
                    $display("%0t: found_client exp %h got %h", $time,
                             want.client, found_client);
                end
                if (found_bound !== want.bound)
                begin
                    errors++;
                    $display("%0t: found_bound exp %h got %h", $time,
                             want.bound, found_bound);
                end
                if (entries_used !== want.used)
                begin
                    errors++;
                    $display("%0t: entries_used exp %0d got %0d", $time,
                             want.used, entries_used);
                end
            end
        end
    end

    task automatic idle_gap();
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = 0;
        if (!no_idle)
        begin
            if (r >= 90)
                gap = $urandom_range(10, 60);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_request(logic rq, logic [6:0] typ, logic [31:0] win,
                                logic [31:0] hnd, logic [31:0] cw, logic [31:0] bw);
        start       <= 1'b1;
        req_type    <= rq;
        event_type  <= typ;
        window_id   <= win;
        handler_id  <= hnd;
        client_word <= cw;
        bound_word  <= bw;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(table_lookup_update(rq, typ, win, hnd, cw, bw));
        if (rq == 1'b0)
            stored_keys.push_back({typ, win});
        idle_gap();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(1'b1, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(1'b0, 7'd0, 32'd0, 32'h1111_0000, 32'hffff_ffff, 32'h0);
        send_request(1'b0, 7'd127, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff);
        send_request(1'b1, 7'd127, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
        send_request(1'b0, 7'd3, 32'd77, 32'd0, 32'hdead_beef, 32'h1234_5678);
        send_request(1'b1, 7'd3, 32'd77, 32'hffff_ffff, 32'd0, 32'd0);
        send_request(1'b0, 7'd3, 32'd77, 32'h0000_0042, 32'h5555_5555, 32'haaaa_aaaa);
        send_request(1'b1, 7'd3, 32'd77, 32'd0, 32'd0, 32'd0);
        // same home slot, probe chain
        send_request(1'b0, 7'd0, 32'd1, 32'd1, 32'd2, 32'd3);
        send_request(1'b0, 7'd0, 32'hffff_ffff, 32'd4, 32'd5, 32'd6);
        send_request(1'b0, 7'd5, 32'd0, 32'd7, 32'd8, 32'd9);
        send_request(1'b1, 7'd0, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 7'd5, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 7'd0, 32'd12345, 32'd0, 32'd0, 32'd0);
        // wrap from last slot
        send_request(1'b0, 7'd1, 32'd1020, 32'haaaa_aaaa, 32'd1, 32'd2);
        send_request(1'b0, 7'd2, 32'd510, 32'h5555_5555, 32'd3, 32'd4);
        send_request(1'b1, 7'd2, 32'd510, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 7'd1, 32'd1020, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 7'd64, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_random();
        logic [38:0] key;
        logic        rq;
        int          r;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 250 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (i == RAND_ITEMS / 2)
                wait_drained();
            rq = 1'($urandom_range(0, 1));
            r  = $urandom_range(0, 99);
            if (r < 60 && stored_keys.size() != 0)
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else if (r < 75)
                key = {7'd0, 32'($urandom)};
            else
                key = {7'($urandom), 32'($urandom)};
            send_request(rq, key[38:32], key[31:0], ($urandom_range(0, 9) == 0) ? 32'd0
                         : 32'($urandom), 32'($urandom), 32'($urandom));
        end
        no_idle = 0;
        wait_drained();
    endtask

    task automatic test_full_table();
        for (int j = 0; j < SLOTS; j++)
            if (!tbl_valid[j])
                send_request(1'b0, 7'd1, 32'(j), 32'($urandom), 32'($urandom),
                             32'($urandom));
        send_request(1'b0, 7'd9, 32'h0bad_f00d, 32'd1, 32'd2, 32'd3);
        send_request(1'b0, 7'd127, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 7'd127, 32'hffff_ffff, 32'd0, 32'd0, 32'd0);
        send_request(1'b1, 7'd9, 32'h0bad_f00d, 32'd0, 32'd0, 32'd0);
        send_request(1'b0, 7'd100, 32'h7777_7777, 32'd1, 32'd2, 32'd3);
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = 1'b0;
        event_type  = '0;
        window_id   = '0;
        handler_id  = '0;
        client_word = '0;
        bound_word  = '0;
        errors      = 0;
        cycles      = 0;
        no_idle     = 0;
        tbl_used    = 0;
        for (int j = 0; j < SLOTS; j++)
            tbl_valid[j] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_full_table();
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("event_handler_hash_table_tb: PASS");
        else
            $display("event_handler_hash_table_tb: FAIL");
        $finish;
    end

endmodule
